[design/cd2d_pkg.sv]
// Package: shared widths, pair kind codes and the stage word type of contact_detect_2d.
package cd2d_pkg;

  localparam int CoordBits = 32;
  localparam int FracBits  = 16;
  localparam int NormBits  = FracBits + 2;
  localparam int ExtBits   = CoordBits - 1;
  localparam int DiffBits  = CoordBits + 2;
  localparam int SqBits    = 2 * DiffBits + 1;
  localparam int RootBits  = (SqBits + 1) / 2;
  localparam int QuoBits   = FracBits + 2;
  localparam int EpsRaw    = ((1 << FracBits) + 500) / 1000;

  localparam logic [2:0] KindBoxBox  = 3'd0;
  localparam logic [2:0] KindBoxCirc = 3'd1;
  localparam logic [2:0] KindCircBox = 3'd2;
  localparam logic [2:0] KindCircCirc = 3'd3;

  // Geometry word after the front stage: differences and squared lengths.
  typedef struct packed {
    logic                        box_box;
    logic                        circ;       // box-circle or circle-circle path
    logic                        circ_circ;
    logic                        hit;
    logic                        solid;
    logic                        swapped;
    logic signed [DiffBits-1:0]  vx;         // vector that gets normalized
    logic signed [DiffBits-1:0]  vy;
    logic [SqBits-1:0]           sq;         // |v|^2
    logic signed [DiffBits-1:0]  pnt_x;
    logic signed [DiffBits-1:0]  pnt_y;
    logic signed [DiffBits-1:0]  base_pen;   // penetration before the root is taken off
    logic signed [NormBits-1:0]  box_nx;
    logic signed [NormBits-1:0]  box_ny;
    logic [NormBits-1:0]         bounce;
  } geo_t;

  function automatic logic signed [CoordBits-1:0] sat_coord(
      input logic signed [DiffBits+1:0] v);
    logic signed [DiffBits+1:0] mx;
    logic signed [DiffBits+1:0] mn;
    mx = (DiffBits+2)'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
    mn = -mx - (DiffBits+2)'(1);
    if (v > mx) return mx[CoordBits-1:0];
    if (v < mn) return mn[CoordBits-1:0];
    return v[CoordBits-1:0];
  endfunction

endpackage

[design/cd2d_front.sv]
// Front stages: pair decode and clamping, then squared distances and the overlap test.
module cd2d_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  output logic                              vld_o,
  input  logic [2:0]                        pair_kind_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_a_x_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_a_y_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_b_x_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_b_y_i,
  input  logic [cd2d_pkg::ExtBits-1:0]      extent_a_x_i,
  input  logic [cd2d_pkg::ExtBits-1:0]      extent_a_y_i,
  input  logic [cd2d_pkg::ExtBits-1:0]      extent_b_x_i,
  input  logic [cd2d_pkg::ExtBits-1:0]      extent_b_y_i,
  input  logic [cd2d_pkg::NormBits-1:0]     bounce_a_i,
  input  logic [cd2d_pkg::NormBits-1:0]     bounce_b_i,
  input  logic                              sensor_only_i,
  output cd2d_pkg::geo_t                    geo_o
);
  localparam int CB = cd2d_pkg::CoordBits;
  localparam int DB = cd2d_pkg::DiffBits;
  localparam int SB = cd2d_pkg::SqBits;
  localparam int NB = cd2d_pkg::NormBits;

  logic vld_q, sq_vld_q;
  cd2d_pkg::geo_t geo_q, geo_d, sq_geo_q, sq_geo_d;

  logic signed [DB-1:0] ax, ay, bx, by, eax, eay, ebx, eby;
  logic signed [DB-1:0] dx, dy, adx, ady, penx, peny;
  logic signed [DB-1:0] qx, qy, hx, hy, cx, cy, rr, ex, ey, kx, ky, gx, gy, rs;
  logic [DB-1:0] vmag_x, vmag_y, rmag;
  logic [CB-1:0] mx, my, mr;
  logic [2*CB-1:0] sqx, sqy, r2;
  logic [SB-1:0] sq;

  always_comb begin
    ax = DB'(center_a_x_i);  ay = DB'(center_a_y_i);
    bx = DB'(center_b_x_i);  by = DB'(center_b_y_i);
    eax = DB'({1'b0, extent_a_x_i}); eay = DB'({1'b0, extent_a_y_i});
    ebx = DB'({1'b0, extent_b_x_i}); eby = DB'({1'b0, extent_b_y_i});
    dx = ax - bx;
    dy = ay - by;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    penx = eax + ebx - adx;
    peny = eay + eby - ady;
    if (pair_kind_i == cd2d_pkg::KindCircBox) begin
      qx = bx; qy = by; hx = ebx; hy = eby; cx = ax; cy = ay; rr = eax;
    end else begin
      qx = ax; qy = ay; hx = eax; hy = eay; cx = bx; cy = by; rr = ebx;
    end
    ex = cx - qx;
    ey = cy - qy;
    kx = ex < -hx ? -hx : (ex > hx ? hx : ex);
    ky = ey < -hy ? -hy : (ey > hy ? hy : ey);
    gx = kx - ex;
    gy = ky - ey;
    rs = eax + ebx;

    geo_d = '0;
    geo_d.solid  = ~sensor_only_i;
    geo_d.bounce = bounce_a_i > bounce_b_i ? bounce_a_i : bounce_b_i;
    case (pair_kind_i)
      cd2d_pkg::KindBoxBox: begin
        geo_d.box_box = 1'b1;
        geo_d.hit = penx >= 0 && peny >= 0;
        geo_d.pnt_x = ax + (dx >>> 1);
        geo_d.pnt_y = ay + (dy >>> 1);
        if (penx < peny) begin
          geo_d.box_nx = dx > 0 ? NB'(1 << cd2d_pkg::FracBits)
                                : -NB'(1 << cd2d_pkg::FracBits);
          geo_d.base_pen = penx;
        end else begin
          geo_d.box_ny = dy > 0 ? NB'(1 << cd2d_pkg::FracBits)
                                : -NB'(1 << cd2d_pkg::FracBits);
          geo_d.base_pen = peny;
        end
      end
      cd2d_pkg::KindBoxCirc, cd2d_pkg::KindCircBox: begin
        geo_d.circ = 1'b1;
        geo_d.swapped = pair_kind_i == cd2d_pkg::KindCircBox;
        geo_d.vx = gx; geo_d.vy = gy;
        geo_d.pnt_x = qx + kx;
        geo_d.pnt_y = qy + ky;
        geo_d.base_pen = rr;
      end
      cd2d_pkg::KindCircCirc: begin
        geo_d.circ = 1'b1;
        geo_d.circ_circ = 1'b1;
        geo_d.vx = dx; geo_d.vy = dy;
        geo_d.pnt_x = ax + (dx >>> 1);
        geo_d.pnt_y = ay + (dy >>> 1);
        geo_d.base_pen = rs;
      end
      default: geo_d.hit = 1'b0;
    endcase
  end

  // Second stage squares the vector and the radius and settles the circle overlap.
  always_comb begin
    vmag_x = DB'(geo_q.vx < 0 ? -geo_q.vx : geo_q.vx);
    vmag_y = DB'(geo_q.vy < 0 ? -geo_q.vy : geo_q.vy);
    rmag = geo_q.base_pen;
    // On the circle paths these magnitudes stay below 2^CoordBits.
    mx = vmag_x[CB-1:0];
    my = vmag_y[CB-1:0];
    mr = rmag[CB-1:0];
    sqx = mx * mx;
    sqy = my * my;
    r2 = mr * mr;
    sq = SB'(sqx) + SB'(sqy);
    sq_geo_d = geo_q;
    sq_geo_d.sq = sq;
    if (geo_q.circ_circ) begin
      sq_geo_d.hit = SB'(r2) > sq;
    end else if (geo_q.circ) begin
      sq_geo_d.hit = sq <= SB'(r2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      sq_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q    <= vld_i;
      sq_vld_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q    <= geo_d;
      sq_geo_q <= sq_geo_d;
    end
  end

  assign vld_o = sq_vld_q;
  assign geo_o = sq_geo_q;
endmodule

[design/cd2d_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module cd2d_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  cd2d_pkg::geo_t                geo_i,
  output logic                          vld_o,
  output cd2d_pkg::geo_t                geo_o,
  output logic [cd2d_pkg::RootBits-1:0] root_o
);
  localparam int RB = cd2d_pkg::RootBits;

  logic            vld_q [RB];
  cd2d_pkg::geo_t  geo_q [RB];
  logic [RB-1:0]   root_q [RB];
  logic [2*RB-1:0] rem_q [RB];

  // Each stage tries one bit from the top down. The remainder holds sq - root^2, and
  // setting bit b grows the square by root * 2^(b+1) + 2^(2b), so no multiplier is needed.
  for (genvar s = 0; s < RB; s++) begin : g_stage
    localparam int Bt = RB - 1 - s;
    logic [RB-1:0]   r_in;
    logic [2*RB-1:0] rem_in, inc;
    cd2d_pkg::geo_t  g_in;
    logic            v_in;
    logic            take;
    if (s == 0) begin : g_first
      assign r_in   = '0;
      assign rem_in = (2*RB)'(geo_i.sq);
      assign g_in   = geo_i;
      assign v_in   = vld_i;
    end else begin : g_next
      assign r_in   = root_q[s-1];
      assign rem_in = rem_q[s-1];
      assign g_in   = geo_q[s-1];
      assign v_in   = vld_q[s-1];
    end
    always_comb begin
      inc  = ((2*RB)'(r_in) << (Bt + 1)) + ((2*RB)'(1) << (2 * Bt));
      take = rem_in >= inc;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        geo_q[s]  <= g_in;
        root_q[s] <= take ? (r_in | (RB'(1) << Bt)) : r_in;
        rem_q[s]  <= take ? rem_in - inc : rem_in;
      end
    end
  end

  assign vld_o  = vld_q[RB-1];
  assign geo_o  = geo_q[RB-1];
  assign root_o = root_q[RB-1];
endmodule

[design/cd2d_norm.sv]
// Pipelined restoring divider that turns a vector component into a normal component.
module cd2d_norm (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  cd2d_pkg::geo_t                        geo_i,
  input  logic [cd2d_pkg::RootBits-1:0]         root_i,
  output logic                                  vld_o,
  output cd2d_pkg::geo_t                        geo_o,
  output logic [cd2d_pkg::RootBits-1:0]         root_o,
  output logic signed [cd2d_pkg::NormBits-1:0]  nx_o,
  output logic signed [cd2d_pkg::NormBits-1:0]  ny_o
);
  localparam int RB = cd2d_pkg::RootBits;
  localparam int QB = cd2d_pkg::QuoBits;
  localparam int DB = cd2d_pkg::DiffBits;
  localparam int NB = RB + cd2d_pkg::FracBits + 1;  // numerator width

  logic           vld_q  [QB+1];
  cd2d_pkg::geo_t geo_q  [QB+1];
  logic [RB-1:0]  root_q [QB+1];
  logic [NB-1:0]  remx_q [QB+1], remy_q [QB+1];
  logic [QB-1:0]  qx_q   [QB+1], qy_q   [QB+1];

  logic [DB-1:0] magx, magy;
  logic [NB-1:0] numx, numy;

  // Setup stage: numerators |v|*2^F + len/2 (quotient fits in QuoBits since |v| <= len).
  always_comb begin
    magx = DB'(geo_i.vx < 0 ? -geo_i.vx : geo_i.vx);
    magy = DB'(geo_i.vy < 0 ? -geo_i.vy : geo_i.vy);
    numx = (NB'(magx) << cd2d_pkg::FracBits) + NB'(root_i >> 1);
    numy = (NB'(magy) << cd2d_pkg::FracBits) + NB'(root_i >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q[0] <= geo_i; root_q[0] <= root_i;
      remx_q[0] <= numx; remy_q[0] <= numy;
      qx_q[0] <= '0; qy_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int Sh = QB - s;
    logic [NB-1:0] dsh;
    logic          tx, ty;
    always_comb begin
      dsh = NB'(root_q[s-1]) << Sh;
      tx = (root_q[s-1] != '0) && ((remx_q[s-1] >> Sh) >= NB'(root_q[s-1]));
      ty = (root_q[s-1] != '0) && ((remy_q[s-1] >> Sh) >= NB'(root_q[s-1]));
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        geo_q[s]  <= geo_q[s-1];
        root_q[s] <= root_q[s-1];
        remx_q[s] <= tx ? remx_q[s-1] - dsh : remx_q[s-1];
        remy_q[s] <= ty ? remy_q[s-1] - dsh : remy_q[s-1];
        qx_q[s]   <= qx_q[s-1] | (QB'(tx) << Sh);
        qy_q[s]   <= qy_q[s-1] | (QB'(ty) << Sh);
      end
    end
  end

  always_comb begin
    nx_o = geo_q[QB].vx < 0 ? -$signed(qx_q[QB]) : $signed(qx_q[QB]);
    ny_o = geo_q[QB].vy < 0 ? -$signed(qy_q[QB]) : $signed(qy_q[QB]);
  end

  assign vld_o  = vld_q[QB];
  assign geo_o  = geo_q[QB];
  assign root_o = root_q[QB];
endmodule

[design/contact_detect_2d.sv]
// Top level: contact_detect_2d pipeline with front stage, root, divider and output stage.
//
//  channel   signals                         direction
//  in        in_valid_i / in_ready_o + fields  into the block
//  out       out_valid_o / out_ready_i + fields out of the block
//
// One pair enters per cycle while in_ready_o is high; the path runs through the front
// stages, the bit-per-stage square root and normal divider pipelines, and the output stage.
// Reset clears every valid bit; payload registers are not reset.
// The pipeline advances whenever the output register is empty or being taken, so a
// stall freezes every stage and loses or repeats nothing.
module contact_detect_2d (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [2:0]                            pair_kind_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_a_x_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_a_y_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_b_x_i,
  input  logic signed [cd2d_pkg::CoordBits-1:0] center_b_y_i,
  input  logic [cd2d_pkg::ExtBits-1:0]          extent_a_x_i,
  input  logic [cd2d_pkg::ExtBits-1:0]          extent_a_y_i,
  input  logic [cd2d_pkg::ExtBits-1:0]          extent_b_x_i,
  input  logic [cd2d_pkg::ExtBits-1:0]          extent_b_y_i,
  input  logic [cd2d_pkg::NormBits-1:0]         bounce_a_i,
  input  logic [cd2d_pkg::NormBits-1:0]         bounce_b_i,
  input  logic                                  sensor_only_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  intersects_o,
  output logic                                  contact_written_o,
  output logic                                  swapped_o,
  output logic signed [cd2d_pkg::NormBits-1:0]  normal_x_o,
  output logic signed [cd2d_pkg::NormBits-1:0]  normal_y_o,
  output logic signed [cd2d_pkg::CoordBits-1:0] point_x_o,
  output logic signed [cd2d_pkg::CoordBits-1:0] point_y_o,
  output logic signed [cd2d_pkg::CoordBits-1:0] penetration_o,
  output logic [cd2d_pkg::NormBits-1:0]         bounce_out_o
);
  localparam int NB = cd2d_pkg::NormBits;
  localparam int CB = cd2d_pkg::CoordBits;
  localparam int DB = cd2d_pkg::DiffBits;
  localparam int RB = cd2d_pkg::RootBits;

  logic en, f_vld, s_vld, n_vld, out_vld_q;
  cd2d_pkg::geo_t f_geo, s_geo, n_geo;
  logic [RB-1:0] s_root, n_root;
  logic signed [NB-1:0] n_nx, n_ny;

  logic hit_q, wr_q, sw_q, wr;
  logic signed [NB-1:0] nx_q, ny_q, nx_d, ny_d;
  logic signed [CB-1:0] px_q, py_q, pen_q;
  logic signed [DB+1:0] pen_full;
  logic [NB-1:0] bounce_q;

  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = en;

  cd2d_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .vld_o(f_vld),
    .pair_kind_i, .center_a_x_i, .center_a_y_i, .center_b_x_i, .center_b_y_i,
    .extent_a_x_i, .extent_a_y_i, .extent_b_x_i, .extent_b_y_i,
    .bounce_a_i, .bounce_b_i, .sensor_only_i, .geo_o(f_geo)
  );

  cd2d_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld), .geo_i(f_geo),
    .vld_o(s_vld), .geo_o(s_geo), .root_o(s_root)
  );

  cd2d_norm u_norm (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld), .geo_i(s_geo), .root_i(s_root),
    .vld_o(n_vld), .geo_o(n_geo), .root_o(n_root), .nx_o(n_nx), .ny_o(n_ny)
  );

  always_comb begin
    wr = n_geo.solid & (n_geo.box_box | (n_geo.circ & n_geo.hit));
    nx_d = '0;
    ny_d = '0;
    pen_full = (DB+2)'(n_geo.base_pen);
    if (n_geo.box_box) begin
      nx_d = n_geo.box_nx;
      ny_d = n_geo.box_ny;
    end else if (n_geo.circ) begin
      pen_full = (DB+2)'(n_geo.base_pen) - (DB+2)'({1'b0, n_root});
      if (n_geo.circ_circ && n_root == '0) begin
        ny_d = NB'(1 << cd2d_pkg::FracBits);
      end else if (!n_geo.circ_circ && n_root < RB'(cd2d_pkg::EpsRaw)) begin
        ny_d = -NB'(1 << cd2d_pkg::FracBits);
      end else begin
        nx_d = n_nx;
        ny_d = n_ny;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= n_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q    <= n_geo.hit;
      wr_q     <= wr;
      sw_q     <= n_geo.swapped;
      bounce_q <= n_geo.bounce;
      nx_q     <= wr ? nx_d : '0;
      ny_q     <= wr ? ny_d : '0;
      px_q     <= wr ? cd2d_pkg::sat_coord((DB+2)'(n_geo.pnt_x)) : '0;
      py_q     <= wr ? cd2d_pkg::sat_coord((DB+2)'(n_geo.pnt_y)) : '0;
      pen_q    <= wr ? cd2d_pkg::sat_coord(pen_full) : '0;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign intersects_o      = hit_q;
  assign contact_written_o = wr_q;
  assign swapped_o         = sw_q;
  assign normal_x_o        = nx_q;
  assign normal_y_o        = ny_q;
  assign point_x_o         = px_q;
  assign point_y_o         = py_q;
  assign penetration_o     = pen_q;
  assign bounce_out_o      = bounce_q;
endmodule

[tb/contact_detect_2d_tb.sv]
// Testbench for contact_detect_2d: random and directed shape pairs checked against a predictor.
module contact_detect_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordBits = cd2d_pkg::CoordBits;
  localparam int FracBits  = cd2d_pkg::FracBits;
  localparam int NormBits  = cd2d_pkg::NormBits;
  localparam int ExtBits   = cd2d_pkg::ExtBits;
  localparam int RootBits  = cd2d_pkg::RootBits;
  localparam int QuoBits   = cd2d_pkg::QuoBits;
  localparam int EpsRaw    = cd2d_pkg::EpsRaw;
  localparam logic [2:0] KindBoxBox   = cd2d_pkg::KindBoxBox;
  localparam logic [2:0] KindBoxCirc  = cd2d_pkg::KindBoxCirc;
  localparam logic [2:0] KindCircBox  = cd2d_pkg::KindCircBox;
  localparam logic [2:0] KindCircCirc = cd2d_pkg::KindCircCirc;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 3 + RootBits + QuoBits + 1 + 10;
  localparam logic [2:0] KindUnsupported = 3'd4;
  localparam logic [2:0] KindTopCode = 3'd7;
  localparam logic [NormBits-1:0] BounceMax = NormBits'(131072);
  localparam longint CoordMax = 2147483647;
  localparam longint CoordMin = -CoordMax - 1;

  typedef struct packed {
    logic [2:0]                  kind;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic [ExtBits-1:0]          eax;
    logic [ExtBits-1:0]          eay;
    logic [ExtBits-1:0]          ebx;
    logic [ExtBits-1:0]          eby;
    logic [NormBits-1:0]         ba;
    logic [NormBits-1:0]         bb;
    logic                        sensor;
  } pair_t;

  typedef struct packed {
    logic                        hit;
    logic                        written;
    logic                        swapped;
    logic signed [NormBits-1:0]  nx;
    logic signed [NormBits-1:0]  ny;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] pen;
    logic [NormBits-1:0]         bounce;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pair_t cur = '0;
  contact_t got;

  pair_t pending_pairs[$];
  contact_t expected_contacts[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;
  logic took = 1'b0;

  contact_detect_2d i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pair_kind_i      (cur.kind),
    .center_a_x_i     (cur.ax),
    .center_a_y_i     (cur.ay),
    .center_b_x_i     (cur.bx),
    .center_b_y_i     (cur.by),
    .extent_a_x_i     (cur.eax),
    .extent_a_y_i     (cur.eay),
    .extent_b_x_i     (cur.ebx),
    .extent_b_y_i     (cur.eby),
    .bounce_a_i       (cur.ba),
    .bounce_b_i       (cur.bb),
    .sensor_only_i    (cur.sensor),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .intersects_o     (got.hit),
    .contact_written_o(got.written),
    .swapped_o        (got.swapped),
    .normal_x_o       (got.nx),
    .normal_y_o       (got.ny),
    .point_x_o        (got.px),
    .point_y_o        (got.py),
    .penetration_o    (got.pen),
    .bounce_out_o     (got.bounce)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] len_sq(longint x, longint y);
    logic [127:0] a;
    logic [127:0] b;
    a = 128'(mag(x));
    b = 128'(mag(y));
    return a * a + b * b;
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] s);
    logic [63:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = 128'(r | (64'd1 << b));
      if (t * t <= s) r = t[63:0];
    end
    return r;
  endfunction

  // Rounded v * 2^FracBits / len, ties away from zero.
  function automatic longint unit_comp(longint v, logic [63:0] len);
    logic [127:0] num;
    logic [127:0] q;
    num = (128'(mag(v)) << FracBits) + 128'(len >> 1);
    q = num / 128'(len);
    return v < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic signed [CoordBits-1:0] clip_coord(longint v);
    longint mx;
    mx = (longint'(1) <<< (CoordBits - 1)) - 1;
    if (v > mx) return CoordBits'(mx);
    if (v < -mx - 1) return CoordBits'(-mx - 1);
    return CoordBits'(v);
  endfunction

  function automatic contact_t compute_contact(pair_t p);
    contact_t c;
    longint ax, ay, bx, by, eax, eay, ebx, eby;
    longint dx, dy, penx, peny, nx, ny, px, py, pen;
    longint qx, qy, hx, hy, cx, cy, r, ex, ey, kx, ky, gx, gy, rs;
    logic [127:0] s2;
    logic [63:0] len;
    logic solid;
    c = '0;
    ax = longint'(p.ax); ay = longint'(p.ay);
    bx = longint'(p.bx); by = longint'(p.by);
    eax = longint'(p.eax); eay = longint'(p.eay);
    ebx = longint'(p.ebx); eby = longint'(p.eby);
    solid = !p.sensor;
    nx = 0; ny = 0; px = 0; py = 0; pen = 0;
    c.bounce = p.ba > p.bb ? p.ba : p.bb;
    case (p.kind)
      KindBoxBox: begin
        dx = ax - bx; dy = ay - by;
        penx = eax + ebx - longint'(mag(dx));
        peny = eay + eby - longint'(mag(dy));
        c.hit = penx >= 0 && peny >= 0;
        if (solid) begin
          // Boxes write a contact even when apart; depth goes negative.
          c.written = 1'b1;
          px = ax + (dx >>> 1);
          py = ay + (dy >>> 1);
          if (penx < peny) begin
            nx = dx > 0 ? 1 : -1;
            pen = penx;
          end else begin
            ny = dy > 0 ? 1 : -1;
            pen = peny;
          end
          nx = nx <<< FracBits;
          ny = ny <<< FracBits;
        end
      end
      KindBoxCirc, KindCircBox: begin
        if (p.kind == KindCircBox) begin
          c.swapped = 1'b1;
          qx = bx; qy = by; hx = ebx; hy = eby; cx = ax; cy = ay; r = eax;
        end else begin
          qx = ax; qy = ay; hx = eax; hy = eay; cx = bx; cy = by; r = ebx;
        end
        ex = cx - qx; ey = cy - qy;
        kx = ex < -hx ? -hx : (ex > hx ? hx : ex);
        ky = ey < -hy ? -hy : (ey > hy ? hy : ey);
        gx = kx - ex; gy = ky - ey;
        s2 = len_sq(gx, gy);
        c.hit = s2 <= 128'(r) * 128'(r);
        if (c.hit && solid) begin
          len = floor_root(s2);
          c.written = 1'b1;
          px = qx + kx;
          py = qy + ky;
          pen = r - longint'(len);
          // A circle center inside the box or closer to it than EpsRaw gets a fixed downward normal.
          if (len < 64'(EpsRaw)) begin
            ny = -(longint'(1) <<< FracBits);
          end else begin
            nx = unit_comp(gx, len);
            ny = unit_comp(gy, len);
          end
        end
      end
      KindCircCirc: begin
        dx = ax - bx; dy = ay - by; rs = eax + ebx;
        s2 = len_sq(dx, dy);
        c.hit = !(128'(rs) * 128'(rs) <= s2);
        if (c.hit && solid) begin
          len = floor_root(s2);
          c.written = 1'b1;
          if (len == 0) begin
            ny = longint'(1) <<< FracBits;
          end else begin
            nx = unit_comp(dx, len);
            ny = unit_comp(dy, len);
          end
          px = ax + (dx >>> 1);
          py = ay + (dy >>> 1);
          pen = rs - longint'(len);
        end
      end
      default: begin
      end
    endcase
    c.nx = NormBits'(nx);
    c.ny = NormBits'(ny);
    c.px = clip_coord(px);
    c.py = clip_coord(py);
    c.pen = clip_coord(pen);
    return c;
  endfunction

  function automatic pair_t make_pair(logic [2:0] kind, longint ax, longint ay, longint bx,
                                      longint by, longint eax, longint eay, longint ebx,
                                      longint eby, bit sensor);
    pair_t p;
    p.kind = kind;
    p.ax = CoordBits'(ax); p.ay = CoordBits'(ay);
    p.bx = CoordBits'(bx); p.by = CoordBits'(by);
    p.eax = ExtBits'(eax); p.eay = ExtBits'(eay);
    p.ebx = ExtBits'(ebx); p.eby = ExtBits'(eby);
    p.ba = NormBits'($urandom_range(0, 131072));
    p.bb = NormBits'($urandom_range(0, 131072));
    p.sensor = sensor;
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int sh;
    int span;
    p.kind = ($urandom_range(0, 19) == 0) ? KindUnsupported : 3'($urandom_range(0, 3));
    p.ba = NormBits'($urandom_range(0, 131072));
    p.bb = NormBits'($urandom_range(0, 131072));
    p.sensor = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 2) begin
      p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
      p.eax = ExtBits'($urandom); p.eay = ExtBits'($urandom);
      p.ebx = ExtBits'($urandom); p.eby = ExtBits'($urandom);
    end else begin
      // Shapes of similar size placed close together, so most pairs are near contact.
      sh = $urandom_range(4, 28);
      span = 1 << (sh + 1);
      p.eax = ExtBits'($urandom_range(0, span - 1));
      p.eay = ExtBits'($urandom_range(0, span - 1));
      p.ebx = ExtBits'($urandom_range(0, span - 1));
      p.eby = ExtBits'($urandom_range(0, span - 1));
      p.ax = $urandom;
      p.ay = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        p.bx = p.ax;
        p.by = p.ay;
      end else begin
        p.bx = p.ax + CoordBits'($urandom_range(0, 2 * span - 1)) - CoordBits'(span);
        p.by = p.ay + CoordBits'($urandom_range(0, 2 * span - 1)) - CoordBits'(span);
      end
    end
    return p;
  endfunction

  task automatic add_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) add_pair(random_pair());
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Driver: a word is held until taken, then the next one or an idle cycle follows.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_ni && !(in_valid_i && !took)) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur <= pending_pairs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: accepted inputs queue a prediction, accepted outputs are checked in order.
  always @(posedge clk_i) begin
    contact_t want;
    took <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_contacts.insert(expected_contacts.size(), compute_contact(cur));
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_contacts.size() == 0) begin
        if (errors < 10) $display("Unexpected result word: %p", got);
        errors++;
      end else begin
        want = expected_contacts.pop_front();
        if (got.hit !== want.hit || got.written !== want.written ||
            got.swapped !== want.swapped || got.nx !== want.nx || got.ny !== want.ny ||
            got.px !== want.px || got.py !== want.py || got.pen !== want.pen ||
            got.bounce !== want.bounce) begin
          if (errors < 10) $display("Mismatch: expected %p, got %p", want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    pair_t p;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Overlapping boxes, apart boxes, equal depths, boxes on the same center.
    add_pair(make_pair(KindBoxBox, 100, 50, 0, 0, 80, 80, 40, 40, 0));
    add_pair(make_pair(KindBoxBox, -900, 10, 0, 0, 40, 40, 40, 40, 0));
    add_pair(make_pair(KindBoxBox, 30, 30, 0, 0, 50, 50, 50, 50, 0));
    add_pair(make_pair(KindBoxBox, 7, 7, 7, 7, 1, 1, 1, 1, 0));
    // Opposite corners of the coordinate range with the largest extents saturate.
    add_pair(make_pair(KindBoxBox, CoordMax, CoordMax, CoordMin, CoordMin,
                       2147483647, 2147483647, 2147483647, 2147483647, 0));
    add_pair(make_pair(KindCircCirc, CoordMin, CoordMax, CoordMax, CoordMin,
                       2147483647, 0, 2147483647, 0, 0));
    add_pair(make_pair(KindBoxCirc, CoordMax, CoordMin, CoordMin, CoordMax,
                       2147483647, 2147483647, 2147483647, 2147483647, 0));
    // Circle center inside the box, a circle touching the box edge exactly, and a corner overlap.
    add_pair(make_pair(KindBoxCirc, 0, 0, 10, 20, 1000, 1000, 5, 0, 0));
    add_pair(make_pair(KindBoxCirc, 0, 0, 1300, 0, 1000, 1000, 300, 0, 0));
    add_pair(make_pair(KindBoxCirc, 0, 0, 70000, 70000, 65536, 65536, 8000, 0, 0));
    // Circle-box is the same geometry with the operands exchanged.
    add_pair(make_pair(KindCircBox, 70000, 70000, 0, 0, 8000, 0, 65536, 65536, 0));
    add_pair(make_pair(KindCircBox, 5, 5, 0, 0, 3, 0, 100, 100, 0));
    // Coincident circle centers, circles exactly tangent, and a plain overlap.
    add_pair(make_pair(KindCircCirc, 1234, -5678, 1234, -5678, 10, 0, 20, 0, 0));
    add_pair(make_pair(KindCircCirc, 300, 400, 0, 0, 200, 0, 300, 0, 0));
    add_pair(make_pair(KindCircCirc, -300, 400, 0, 0, 400, 0, 300, 0, 0));
    // Trigger pairs: overlap flag only.
    add_pair(make_pair(KindBoxBox, 10, 10, 0, 0, 50, 50, 50, 50, 1));
    add_pair(make_pair(KindCircCirc, 10, 10, 0, 0, 50, 0, 50, 0, 1));
    add_pair(make_pair(KindBoxCirc, 10, 10, 0, 0, 50, 50, 50, 50, 1));
    // Unsupported kinds still carry the larger restitution.
    add_pair(make_pair(KindUnsupported, 0, 0, 0, 0, 5, 5, 5, 5, 0));
    add_pair(make_pair(KindTopCode, 0, 0, 0, 0, 5, 5, 5, 5, 0));
    p = make_pair(KindBoxBox, 0, 0, 1, 1, 2, 2, 2, 2, 0);
    p.ba = '0; p.bb = BounceMax;
    add_pair(p);
    p.ba = BounceMax; p.bb = '0;
    add_pair(p);

    run_phase(0, 0, 300);
    run_phase(87, 0, 230);
    run_phase(0, 87, 230);
    run_phase(27, 27, 230);
    run_phase(0, 0, 80);
    run_phase(87, 87, 180);

    while (in_valid_i || expected_contacts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/cd2d_pkg.sv
design/cd2d_front.sv
design/cd2d_sqrt.sv
design/cd2d_norm.sv
design/contact_detect_2d.sv
tb/contact_detect_2d_tb.sv
